### hw/rtl/fslm_pkg.sv
// Shared types, constants and helpers of the fixed-string line matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fslm_pkg;

    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int BYTE_W          = 8;
    localparam int PAT_BYTES       = 32;
    localparam int PAT_IDX_W       = 5;
    localparam int PAT_WORDS       = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int PAT_LEN_W       = 6;
    localparam int MODE_W          = 2;
    localparam int OFF_W           = 16;
    localparam int Q_DEPTH         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW      = 3'd0,
        CFG_PAT_MID_LOW  = 3'd1,
        CFG_PAT_MID_HIGH = 3'd2,
        CFG_PAT_HIGH     = 3'd3,
        CFG_PAT_LEN      = 3'd4,
        CFG_FOLD         = 3'd5,
        CFG_MODE         = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
        logic                             fold;
        logic                             word_mode;
        logic                             line_mode;
    } t_cfg;

    typedef struct packed {
        logic present;
        logic line_end;
        logic wc;
        logic seed;
        logic cand;
    } t_item_flags;

    function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fixed_string_line_matcher_top.sv
// Fixed-string line matcher top: configuration registers, front, queue and back.
// Result path: a line-end item is stored in the queue, then its result is registered in the
// back part's output, later while earlier items are queued or a previous result is held.
// Throughput: one item per cycle; input stalls only once the queue fills behind a held result.
// Reset: synchronous, active low; configuration reads zero and line state is cleared,
// with no clearing pass. Depends on fslm_pkg, fslm_front, fslm_queue and fslm_back.
`timescale 1ns / 1ps
`default_nettype none

module fixed_string_line_matcher_top import fslm_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [BYTE_W-1:0]     i_text_byte,
    input  wire logic                  i_byte_present,
    input  wire logic                  i_line_end,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_line_matched,
    output logic [OFF_W-1:0]           o_match_offset,
    output logic [OFF_W-1:0]           o_match_end_offset
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int QW = $bits(t_item_flags) + COUNT_WIDTH;

    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [PAT_LEN_W-1:0]                 r_pat_len;
    logic                                 r_fold;
    logic [MODE_W-1:0]                    r_mode;
    t_cfg                                 cfg;
    logic [LW-1:0]                        len;
    logic                                 cfg_we;

    logic                   f_valid, f_ready, q_valid, q_ready;
    t_item_flags            f_flags, q_flags;
    logic [COUNT_WIDTH-1:0] f_start, q_start;
    logic [QW-1:0]          q_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat     <= '0;
            r_pat_len <= '0;
            r_fold    <= 1'b0;
            r_mode    <= '0;
        end else if (cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PAT_LOW:      r_pat[0]  <= i_cfg_data;
                CFG_PAT_MID_LOW:  r_pat[1]  <= i_cfg_data;
                CFG_PAT_MID_HIGH: r_pat[2]  <= i_cfg_data;
                CFG_PAT_HIGH:     r_pat[3]  <= i_cfg_data;
                CFG_PAT_LEN:      r_pat_len <= i_cfg_data[PAT_LEN_W-1:0];
                CFG_FOLD:         r_fold    <= i_cfg_data[0];
                CFG_MODE:         r_mode    <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.pat       = r_pat;
        cfg.fold      = r_fold;
        cfg.word_mode = r_mode[0];
        cfg.line_mode = r_mode[1];
        len = ({1'b0, r_pat_len} > (PAT_LEN_W + 1)'(MAX_PATTERN)) ?
              LW'(MAX_PATTERN) : LW'(r_pat_len);
    end

    fslm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_len          (len),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_byte_present (i_byte_present),
        .i_line_end     (i_line_end),
        .i_q_ready      (f_ready),
        .o_q_valid      (f_valid),
        .o_flags        (f_flags),
        .o_start        (f_start)
    );

    fslm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_flags, f_start}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign q_flags = t_item_flags'(q_data[QW-1:COUNT_WIDTH]);
    assign q_start = q_data[COUNT_WIDTH-1:0];

    fslm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_len              (len),
        .i_q_valid          (q_valid),
        .o_q_ready          (q_ready),
        .i_flags            (q_flags),
        .i_start            (q_start),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_line_matched     (o_line_matched),
        .o_match_offset     (o_match_offset),
        .o_match_end_offset (o_match_end_offset)
    );

endmodule

`default_nettype wire

### hw/rtl/fslm_front.sv
// Front part: accepts line bytes, keeps the byte window and count, classifies hits.
// Depends on fslm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fslm_front import fslm_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic [LW-1:0]          i_len,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [BYTE_W-1:0]      i_text_byte,
    input  wire logic                   i_byte_present,
    input  wire logic                   i_line_end,
    input  wire logic                   i_q_ready,
    output logic                        o_q_valid,
    output t_item_flags                 o_flags,
    output logic [COUNT_WIDTH-1:0]      o_start
);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] r_win, n_win;
    logic [MAX_PATTERN:0]               r_wf, n_wf;
    logic [COUNT_WIDTH-1:0]             r_cnt, n_cnt;
    logic [MAX_PATTERN-1:0]             match;
    logic [COUNT_WIDTH-1:0]             cnt_inc, start;
    logic                               wc, hit, accept;

    assign o_ready   = i_q_ready;
    assign o_q_valid = i_valid;
    assign accept    = i_valid && i_q_ready;
    assign wc        = is_word_char(i_text_byte);
    assign cnt_inc   = (r_cnt == '1) ? r_cnt : r_cnt + COUNT_WIDTH'(1);

    always_comb begin
        logic [LW-1:0]        diff;
        logic [BYTE_W-1:0]    pb;
        logic [BYTE_W-1:0]    tb;
        n_win[0] = i_text_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
        n_wf = {r_wf[MAX_PATTERN-1:0], wc};
        for (int j = 0; j < MAX_PATTERN; j++) begin
            diff = i_len - LW'(j) - LW'(1);
            pb   = i_cfg.pat[PAT_IDX_W'(diff)];
            tb   = n_win[j];
            if (i_cfg.fold) begin
                pb = lower_ascii(pb);
                tb = lower_ascii(tb);
            end
            match[j] = (LW'(j) >= i_len) || (pb == tb);
        end
    end

    assign hit   = (cnt_inc >= COUNT_WIDTH'(i_len)) && (&match);
    assign start = cnt_inc - COUNT_WIDTH'(i_len);

    always_comb begin
        o_flags.present  = i_byte_present;
        o_flags.line_end = i_line_end;
        o_flags.wc       = wc;
        o_flags.seed     = (r_cnt == '0) && (i_len == '0);
        o_flags.cand     = hit &&
                           !(i_cfg.word_mode && (start != '0) && n_wf[i_len]) &&
                           !(i_cfg.line_mode && (start != '0));
        o_start          = start;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_byte_present) begin
                n_cnt = cnt_inc;
            end
            if (i_line_end) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_byte_present) begin
            r_win <= n_win;
            r_wf  <= n_wf;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fslm_queue.sv
// Short item queue between front and back parts.
// Depends on fslm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fslm_queue import fslm_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [Q_DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [AW-1:0]                 r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                 r_count, n_count;
    logic                          push, pop;

    assign o_push_ready = (r_count != CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fslm_back.sv
// Back part: resolves pending occurrences, keeps the first accepted one, issues results.
// Depends on fslm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fslm_back import fslm_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic [LW-1:0]          i_len,
    input  wire logic                   i_q_valid,
    output logic                        o_q_ready,
    input  wire t_item_flags            i_flags,
    input  wire logic [COUNT_WIDTH-1:0] i_start,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_line_matched,
    output logic [OFF_W-1:0]            o_match_offset,
    output logic [OFF_W-1:0]            o_match_end_offset
);

    logic                   r_pending, n_pending, r_found, n_found;
    logic [COUNT_WIDTH-1:0] r_pend_start, n_pend_start, r_found_start, n_found_start;
    logic                   r_out_valid, n_out_valid, r_matched, n_matched;
    logic [COUNT_WIDTH-1:0] r_off, n_off, r_end_off, n_end_off;
    logic                   pop;
    logic [OFF_W+COUNT_WIDTH-1:0] off_wide, end_wide;

    assign o_q_ready = !i_flags.line_end || !r_out_valid || i_ready;
    assign pop       = i_q_valid && o_q_ready;

    always_comb begin
        logic                   pend;
        logic                   fnd;
        logic [COUNT_WIDTH-1:0] pst;
        logic [COUNT_WIDTH-1:0] fst;
        logic [COUNT_WIDTH:0]   esum;
        pend        = r_pending;
        pst         = r_pend_start;
        fnd         = r_found;
        fst         = r_found_start;
        esum        = '0;
        n_out_valid = r_out_valid && !i_ready;
        n_matched   = r_matched;
        n_off       = r_off;
        n_end_off   = r_end_off;
        if (pop) begin
            if (i_flags.seed) begin
                pend = 1'b1;
                pst  = '0;
            end
            if (i_flags.present) begin
                if (pend && !i_cfg.line_mode && !(i_cfg.word_mode && i_flags.wc) && !fnd) begin
                    fnd = 1'b1;
                    fst = pst;
                end
                pend = i_flags.cand;
                pst  = i_start;
            end
            if (i_flags.line_end) begin
                if (pend && !fnd) begin
                    fnd = 1'b1;
                    fst = pst;
                end
                esum        = {1'b0, fst} + (COUNT_WIDTH + 1)'(i_len);
                n_out_valid = 1'b1;
                n_matched   = fnd;
                n_off       = fnd ? fst : '0;
                n_end_off   = !fnd ? '0 : (esum[COUNT_WIDTH] ? '1 : esum[COUNT_WIDTH-1:0]);
                pend        = 1'b0;
                pst         = '0;
                fnd         = 1'b0;
                fst         = '0;
            end
        end
        n_pending     = pend;
        n_pend_start  = pst;
        n_found       = fnd;
        n_found_start = fst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_start  <= n_pend_start;
        r_found_start <= n_found_start;
        r_matched     <= n_matched;
        r_off         <= n_off;
        r_end_off     <= n_end_off;
    end

    assign off_wide           = {{OFF_W{1'b0}}, r_off};
    assign end_wide           = {{OFF_W{1'b0}}, r_end_off};
    assign o_valid            = r_out_valid;
    assign o_line_matched     = r_matched;
    assign o_match_offset     = off_wide[OFF_W-1:0];
    assign o_match_end_offset = end_wide[OFF_W-1:0];

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for fixed_string_line_matcher_top: directed lines, and random lines
// under several register settings and idling patterns.
// Depends on fslm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module testbench;
    import fslm_pkg::*;

    typedef struct {
        logic [7:0] text;
        bit         present;
        bit         last;
    } t_line_item;

    typedef struct {
        t_cfg_reg    idx;
        logic [63:0] data;
    } t_reg_write;

    typedef struct packed {
        logic        matched;
        logic [15:0] first_pos;
        logic [15:0] end_pos;
    } t_match;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic [BYTE_W-1:0] i_text_byte = '0;
    logic i_byte_present = 1'b0;
    logic i_line_end = 1'b0;
    logic i_ready = 1'b0;
    logic o_cfg_ready;
    logic o_ready;
    logic o_valid;
    logic o_line_matched;
    logic [OFF_W-1:0] o_match_offset;
    logic [OFF_W-1:0] o_match_end_offset;

    t_line_item pending_items[$];
    t_reg_write pending_writes[$];
    t_match     expected_matches[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count = 0;

    // Matcher copy: registers and line state
    bit [63:0]   pat_word [4];
    bit [5:0]    pat_len;
    bit          fold_on;
    bit [1:0]    mode_bits;
    bit [7:0]    window [32];
    bit          word_flags [33];
    int unsigned line_count;
    bit          cand_live;
    int unsigned cand_start;
    bit          found_live;
    int unsigned found_start;

    fixed_string_line_matcher_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_text_byte        (i_text_byte),
        .i_byte_present     (i_byte_present),
        .i_line_end         (i_line_end),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_line_matched     (o_line_matched),
        .o_match_offset     (o_match_offset),
        .o_match_end_offset (o_match_end_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit word_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned i);
        return pat_word[i / 8][8 * (i % 8) +: 8];
    endfunction

    function automatic void note_found(input int unsigned pos);
        if (!found_live) begin
            found_live = 1'b1;
            found_start = pos;
        end
    endfunction

    function automatic void apply_reg(input t_cfg_reg idx, input logic [63:0] d);
        case (idx)
            CFG_PAT_LOW:      pat_word[0] = d;
            CFG_PAT_MID_LOW:  pat_word[1] = d;
            CFG_PAT_MID_HIGH: pat_word[2] = d;
            CFG_PAT_HIGH:     pat_word[3] = d;
            CFG_PAT_LEN:      pat_len = d[5:0];
            CFG_FOLD:         fold_on = d[0];
            CFG_MODE:         mode_bits = d[1:0];
            default: ;
        endcase
    endfunction

    // Advance the line state by one item; return 1 with the result on a line end
    function automatic bit scan_item(input logic [7:0] b, input bit present, input bit last,
                                     output t_match res);
        int unsigned n;
        int unsigned pos;
        int unsigned stop;
        bit wc;
        bit hit;
        logic [7:0] t;
        logic [7:0] p;
        n = (pat_len > 32) ? 32 : pat_len;
        res = '0;
        if (line_count == 0 && n == 0) begin
            cand_live = 1'b1;
            cand_start = 0;
        end
        if (present) begin
            wc = word_byte(b);
            if (cand_live && !mode_bits[1] && !(mode_bits[0] && wc))
                note_found(cand_start);
            cand_live = 1'b0;
            for (int i = 31; i > 0; i--)
                window[i] = window[i - 1];
            window[0] = b;
            for (int i = 32; i > 0; i--)
                word_flags[i] = word_flags[i - 1];
            word_flags[0] = wc;
            if (line_count < 32'hFFFF)
                line_count++;
            hit = (line_count >= n);
            for (int i = 0; hit && i < n; i++) begin
                t = window[n - 1 - i];
                p = pattern_byte(i);
                if (fold_on) begin
                    t = to_lower(t);
                    p = to_lower(p);
                end
                if (t != p)
                    hit = 1'b0;
            end
            if (hit) begin
                pos = line_count - n;
                cand_live = !(mode_bits[0] && pos != 0 && word_flags[n]) &&
                            !(mode_bits[1] && pos != 0);
                cand_start = pos;
            end
        end
        if (!last)
            return 1'b0;
        if (cand_live)
            note_found(cand_start);
        if (found_live) begin
            stop = found_start + n;
            if (stop > 32'hFFFF)
                stop = 32'hFFFF;
            res.matched = 1'b1;
            res.first_pos = found_start[15:0];
            res.end_pos = stop[15:0];
        end
        foreach (window[i])
            window[i] = '0;
        foreach (word_flags[i])
            word_flags[i] = 1'b0;
        line_count = 0;
        cand_live = 1'b0;
        cand_start = 0;
        found_live = 1'b0;
        found_start = 0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_line_item nxt;
        t_match res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (scan_item(i_text_byte, i_byte_present, i_line_end, res))
                    expected_matches.push_back(res);
            end
            if (!i_valid || o_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_text_byte <= nxt.text;
                    i_byte_present <= nxt.present;
                    i_line_end <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg(t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (!i_cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    w = pending_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.idx;
                    i_cfg_data <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_matches.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got %0b %0d %0d", $time,
                             o_line_matched, o_match_offset, o_match_end_offset);
                end else begin
                    want = expected_matches.pop_front();
                    if (o_line_matched !== want.matched) begin
                        err_count++;
                        $display("%0t: line_matched expected %0b got %0b", $time,
                                 want.matched, o_line_matched);
                    end
                    if (o_match_offset !== want.first_pos) begin
                        err_count++;
                        $display("%0t: match_offset expected %0d got %0d", $time,
                                 want.first_pos, o_match_offset);
                    end
                    if (o_match_end_offset !== want.end_pos) begin
                        err_count++;
                        $display("%0t: match_end_offset expected %0d got %0d", $time,
                                 want.end_pos, o_match_end_offset);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] gap_byte();
        case ($urandom_range(5))
            0: return 8'h20;
            1: return 8'h2E;
            2: return 8'h2C;
            3: return 8'h2D;
            4: return 8'h00;
            default: return 8'(8'h80 + $urandom_range(127));
        endcase
    endfunction

    function automatic logic [7:0] any_text_byte();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) return 8'(8'h61 + $urandom_range(25));
        if (pick < 50) return 8'(8'h41 + $urandom_range(25));
        if (pick < 60) return 8'(8'h30 + $urandom_range(9));
        if (pick < 65) return 8'h5F;
        if (pick < 80) return gap_byte();
        if (pick < 86) return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [255:0] pack_text(input string s);
        bit [255:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 32; i++)
            v[8 * i +: 8] = s[i];
        return v;
    endfunction

    task automatic push_item(input logic [7:0] b, input bit present, input bit last);
        t_line_item it;
        it.text = b;
        it.present = present;
        it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic push_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b1, close && i == s.len() - 1);
        if (s.len() == 0 && close)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || i_valid || expected_matches.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_config(input bit [255:0] pat, input bit [5:0] len, input bit fold,
                               input bit [1:0] mode);
        settle();
        pending_writes.push_back('{CFG_PAT_LOW, pat[63:0]});
        pending_writes.push_back('{CFG_PAT_MID_LOW, pat[127:64]});
        pending_writes.push_back('{CFG_PAT_MID_HIGH, pat[191:128]});
        pending_writes.push_back('{CFG_PAT_HIGH, pat[255:192]});
        pending_writes.push_back('{CFG_PAT_LEN, 64'(len)});
        pending_writes.push_back('{CFG_FOLD, 64'(fold)});
        pending_writes.push_back('{CFG_MODE, 64'(mode)});
        while (pending_writes.size() != 0 || i_cfg_valid)
            @(negedge i_clk);
    endtask

    // Mostly lines built round the pattern, some plain noise, some with a corrupted byte
    task automatic push_random_line(inout int unsigned used);
        int unsigned plen;
        int unsigned pick;
        int unsigned reps;
        bit tight;
        bit split;
        logic [7:0] b;
        logic [7:0] line_q[$];
        plen = (pat_len > 32) ? 32 : pat_len;
        pick = $urandom_range(99);
        tight = mode_bits[1] && $urandom_range(1);
        if (pick < 15) begin
            repeat ($urandom_range(24)) line_q.push_back(any_text_byte());
        end else begin
            reps = (pick < 70 || tight) ? 1 : 2;
            repeat (reps) begin
                if (!tight)
                    repeat ($urandom_range(4))
                        line_q.push_back($urandom_range(1) ? any_text_byte() : gap_byte());
                for (int i = 0; i < plen; i++) begin
                    b = pattern_byte(i);
                    if (fold_on && to_lower(b) >= 8'h61 && to_lower(b) <= 8'h7A &&
                        $urandom_range(1))
                        b = b ^ 8'h20;
                    line_q.push_back(b);
                end
            end
            if (!tight)
                repeat ($urandom_range(4))
                    line_q.push_back($urandom_range(1) ? any_text_byte() : gap_byte());
            if (pick >= 88 && line_q.size() != 0)
                line_q[$urandom_range(line_q.size() - 1)] = any_text_byte();
        end
        split = (line_q.size() == 0) || ($urandom_range(99) < 30);
        foreach (line_q[i]) begin
            if ($urandom_range(99) < 6)
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            push_item(line_q[i], 1'b1, !split && i == line_q.size() - 1);
        end
        if (split)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
        used += line_q.size() + split;
    endtask

    task automatic random_phase(input int unsigned k);
        bit [255:0] pat;
        bit [5:0] len;
        int unsigned used;
        settle();
        case (k / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
        case (k)
            0: len = 3;
            1: len = 1;
            2: len = 32;
            3: len = 0;
            4: len = 4;
            5: len = 63;
            6: len = 2;
            default: len = 8;
        endcase
        for (int i = 0; i < 32; i++)
            pat[8 * i +: 8] = any_text_byte();
        load_config(pat, len, k >= 4, k[1:0]);
        used = 0;
        while (used < 155)
            push_random_line(used);
    endtask

    initial begin
        bit [255:0] pat;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_config(pack_text("ab"), 2, 1'b0, 2'd0);
        push_text("", 1'b1);
        push_item(8'($urandom_range(255)), 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_text("ab", 1'b1);
        push_text("xaby", 1'b1);

        load_config(pack_text("aB"), 2, 1'b1, 2'd1);
        push_text("x AB.", 1'b1);
        push_text("Ab ab", 1'b1);

        load_config(pack_text(""), 0, 1'b0, 2'd2);
        push_text("", 1'b1);
        push_text("q", 1'b1);

        pat = pack_text("a");
        pat[23:16] = 8'h62;
        load_config(pat, 3, 1'b0, 2'd0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b1);

        // Change the registers with a line still open
        push_text("xa", 1'b0);
        load_config(pack_text("AB"), 2, 1'b1, 2'd0);
        push_text("b", 1'b1);

        for (int unsigned k = 0; k < 8; k++)
            random_phase(k);

        settle();
        repeat (4) @(negedge i_clk);
        if (err_count == 0 && expected_matches.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
